>>> hw/rtl/wkc_pkg.sv
// ----------------------------------------------------------------------------
// wkc_pkg
// Shared constants, types and helpers of the word keyword counter.
// ----------------------------------------------------------------------------
package wkc_pkg;

  localparam int unsigned NUM_KEYWORDS = 16;
  localparam int unsigned MAX_WORD_LEN = 8;
  localparam int unsigned COUNT_BITS   = 16;

  // Table holds at most 16 entries (4-bit index on the ports).
  localparam int unsigned TABLE_SIZE = (NUM_KEYWORDS < 16) ? NUM_KEYWORDS : 16;
  localparam int unsigned IDX_BITS   = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int unsigned WORD_BITS  = 8 * MAX_WORD_LEN;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Request codes
  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_TEXT = 2'd1;
  localparam logic [1:0] REQ_END  = 2'd2;

  typedef struct packed {
    logic load;      // write keyword entry
    logic add_char;  // append folded character to word
    logic finish;    // latch compare result, clear word
    logic apply;     // bump the latched hit count
    logic emit;      // load next count into output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_sep;     // current text byte ends a word
    logic out_free;   // output register can take an item
    logic dump_last;  // next emitted count is the final one
  } dp_status_t;

  // Reported counts clamp at 16 bits.
  function automatic logic [15:0] report_count(input logic [COUNT_BITS-1:0] c);
    logic [31:0] w;
    w = 32'(c);
    if (w > 32'h0000_FFFF) begin
      return 16'hFFFF;
    end
    return w[15:0];
  endfunction

endpackage

>>> hw/rtl/wkc_req_if.sv
// ----------------------------------------------------------------------------
// wkc_req_if
// Request channel: keyword loads, text bytes and end-of-text marks.
// ----------------------------------------------------------------------------
interface wkc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [7:0]  text_byte;
  logic [3:0]  entry_index;
  logic [63:0] entry_chars;
  logic [3:0]  entry_length;

  modport source (
    output valid, req_type, text_byte, entry_index, entry_chars, entry_length,
    input  ready
  );
  modport sink (
    input  valid, req_type, text_byte, entry_index, entry_chars, entry_length,
    output ready
  );
endinterface

>>> hw/rtl/wkc_cnt_if.sv
// ----------------------------------------------------------------------------
// wkc_cnt_if
// Count channel: one reported keyword count per item.
// ----------------------------------------------------------------------------
interface wkc_cnt_if;
  logic        valid;
  logic        ready;
  logic [3:0]  count_index;
  logic [15:0] match_count;
  logic        last;

  modport source (
    output valid, count_index, match_count, last,
    input  ready
  );
  modport sink (
    input  valid, count_index, match_count, last,
    output ready
  );
endinterface

>>> hw/rtl/wkc_ctrl.sv
// ----------------------------------------------------------------------------
// wkc_ctrl
// Sequencer: accepts requests, steps compare/update and the count dump.
// ----------------------------------------------------------------------------
module wkc_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   req_valid_i,
  input  logic [1:0]             req_type_i,
  output logic                   req_ready_o,
  input  wkc_pkg::dp_status_t    status_i,
  output wkc_pkg::ctrl_cmd_t     cmd_o
);

  localparam logic [1:0] ST_IDLE       = 2'd0;
  localparam logic [1:0] ST_UPDATE     = 2'd1;
  localparam logic [1:0] ST_UPDATE_END = 2'd2;
  localparam logic [1:0] ST_DUMP       = 2'd3;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign req_ready_o = (state_q == ST_IDLE);
  assign accept      = req_valid_i && req_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (req_type_i)
            wkc_pkg::REQ_LOAD: cmd_o.load = 1'b1;
            wkc_pkg::REQ_TEXT: begin
              if (status_i.is_sep) begin
                cmd_o.finish = 1'b1;
                state_d      = ST_UPDATE;
              end else begin
                cmd_o.add_char = 1'b1;
              end
            end
            wkc_pkg::REQ_END: begin
              cmd_o.finish = 1'b1;
              state_d      = ST_UPDATE_END;
            end
            default: ;  // unknown request, dropped
          endcase
        end
      end
      ST_UPDATE: begin
        cmd_o.apply = 1'b1;
        state_d     = ST_IDLE;
      end
      ST_UPDATE_END: begin
        cmd_o.apply = 1'b1;
        state_d     = ST_DUMP;
      end
      ST_DUMP: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.dump_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> hw/rtl/wkc_dp.sv
// ----------------------------------------------------------------------------
// wkc_dp
// Datapath: word builder, keyword table, parallel compare, counts, output.
// ----------------------------------------------------------------------------
module wkc_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  wkc_pkg::ctrl_cmd_t    cmd_i,
  output wkc_pkg::dp_status_t   status_o,
  input  logic [7:0]            text_byte_i,
  input  logic [3:0]            entry_index_i,
  input  logic [63:0]           entry_chars_i,
  input  logic [3:0]            entry_length_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [3:0]            count_index_o,
  output logic [15:0]           match_count_o,
  output logic                  last_o
);

  // keyword table
  logic [63:0]                     kw_text_q [wkc_pkg::TABLE_SIZE];
  logic [3:0]                      kw_len_q  [wkc_pkg::TABLE_SIZE];
  logic [wkc_pkg::COUNT_BITS-1:0]  count_q   [wkc_pkg::TABLE_SIZE];

  // word under construction
  logic [wkc_pkg::WORD_BITS-1:0]   word_q, word_d;
  logic [3:0]                      wlen_q, wlen_d;
  logic                            too_long_q, too_long_d;

  // latched compare result
  logic                            hit_q;
  logic [wkc_pkg::IDX_BITS-1:0]    hit_idx_q;
  logic                            hit_any;
  logic [wkc_pkg::IDX_BITS-1:0]    hit_idx;

  logic [wkc_pkg::IDX_BITS-1:0]    dump_idx_q;

  logic                            out_valid_q;
  logic [3:0]                      out_idx_q;
  logic [15:0]                     out_cnt_q;
  logic                            out_last_q;

  logic                            alnum;
  logic                            upper;
  logic [7:0]                      folded;
  logic [63:0]                     mask;
  logic                            load_ok;
  logic [wkc_pkg::IDX_BITS-1:0]    load_idx;

  assign upper  = (text_byte_i >= 8'h41) && (text_byte_i <= 8'h5A);
  assign alnum  = ((text_byte_i >= 8'h30) && (text_byte_i <= 8'h39)) ||
                  ((text_byte_i >= 8'h61) && (text_byte_i <= 8'h7A)) || upper;
  assign folded = upper ? (text_byte_i | 8'h20) : text_byte_i;

  assign load_ok  = (5'(entry_index_i) < 5'(wkc_pkg::TABLE_SIZE));
  assign load_idx = wkc_pkg::IDX_BITS'(entry_index_i);

  // byte mask covering the current word length
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      mask[8*k +: 8] = (4'(k) < wlen_q) ? 8'hFF : 8'h00;
    end
  end

  // all entries in parallel, lowest index wins
  always_comb begin
    hit_any = 1'b0;
    hit_idx = '0;
    for (int i = wkc_pkg::TABLE_SIZE - 1; i >= 0; i--) begin
      if ((wlen_q != 4'd0) && !too_long_q && (kw_len_q[i] == wlen_q) &&
          ((kw_text_q[i] & mask) == 64'(word_q))) begin
        hit_any = 1'b1;
        hit_idx = wkc_pkg::IDX_BITS'(i);
      end
    end
  end

  // word builder next state
  always_comb begin
    word_d     = word_q;
    wlen_d     = wlen_q;
    too_long_d = too_long_q;
    if (cmd_i.finish) begin
      word_d     = '0;
      wlen_d     = '0;
      too_long_d = 1'b0;
    end else if (cmd_i.add_char) begin
      if (wlen_q < 4'(wkc_pkg::MAX_WORD_LEN)) begin
        for (int k = 0; k < wkc_pkg::MAX_WORD_LEN; k++) begin
          if (wlen_q == 4'(k)) begin
            word_d[8*k +: 8] = folded;
          end
        end
        wlen_d = wlen_q + 4'd1;
      end else begin
        too_long_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q      <= '0;
      wlen_q      <= '0;
      too_long_q  <= 1'b0;
      hit_q       <= 1'b0;
      dump_idx_q  <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < wkc_pkg::TABLE_SIZE; i++) begin
        kw_len_q[i] <= '0;
        count_q[i]  <= '0;
      end
    end else begin
      word_q     <= word_d;
      wlen_q     <= wlen_d;
      too_long_q <= too_long_d;
      if (cmd_i.finish) begin
        hit_q <= hit_any;
      end
      if (cmd_i.load && load_ok) begin
        kw_len_q[load_idx] <= entry_length_i;
      end
      if (cmd_i.apply && hit_q && (count_q[hit_idx_q] != wkc_pkg::COUNT_MAX)) begin
        count_q[hit_idx_q] <= count_q[hit_idx_q] + wkc_pkg::COUNT_BITS'(1);
      end
      if (cmd_i.emit) begin
        count_q[dump_idx_q] <= '0;
        dump_idx_q <= status_o.dump_last ? '0 : dump_idx_q + wkc_pkg::IDX_BITS'(1);
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && load_ok) begin
      kw_text_q[load_idx] <= entry_chars_i;
    end
    if (cmd_i.finish) begin
      hit_idx_q <= hit_idx;
    end
    if (cmd_i.emit) begin
      out_idx_q  <= 4'(dump_idx_q);
      out_cnt_q  <= wkc_pkg::report_count(count_q[dump_idx_q]);
      out_last_q <= status_o.dump_last;
    end
  end

  assign status_o.is_sep    = !alnum;
  assign status_o.out_free  = !out_valid_q || out_ready_i;
  assign status_o.dump_last = (dump_idx_q == wkc_pkg::IDX_BITS'(wkc_pkg::TABLE_SIZE - 1));

  assign out_valid_o   = out_valid_q;
  assign count_index_o = out_idx_q;
  assign match_count_o = out_cnt_q;
  assign last_o        = out_last_q;

endmodule

>>> hw/rtl/word_keyword_counter.sv
// ----------------------------------------------------------------------------
// word_keyword_counter
// Whole-word keyword frequency counter over a byte stream.
// ----------------------------------------------------------------------------
// Per request item: a keyword load, a letter or digit, or an unknown request
// is taken with ready held high. On a separator byte the finished word
// is compared against all table entries at once and the hit is registered,
// then the hit count is bumped in the next cycle. End of text does the same,
// then the counts go out one per cycle from the output register while the
// receiver takes them, TABLE_SIZE items in index order with last on the
// final one, each count cleared as it is read; requests are held off until
// the last count has been loaded into the output register. The count read
// port reads one entry a cycle. Keyword entries never written read as unused
// after reset; counts saturate at all ones and report clamped to 16 bits.
// ----------------------------------------------------------------------------
module word_keyword_counter (
  input  logic      clk_i,
  input  logic      rst_ni,
  wkc_req_if.sink   req_i,
  wkc_cnt_if.source cnt_o
);

  wkc_pkg::ctrl_cmd_t  cmd;
  wkc_pkg::dp_status_t status;

  // sequencer: owns the request handshake and the state
  wkc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_type_i  (req_i.req_type),
    .req_ready_o (req_i.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // datapath: table, word, compare, counts and the output register
  wkc_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .text_byte_i    (req_i.text_byte),
    .entry_index_i  (req_i.entry_index),
    .entry_chars_i  (req_i.entry_chars),
    .entry_length_i (req_i.entry_length),
    .out_ready_i    (cnt_o.ready),
    .out_valid_o    (cnt_o.valid),
    .count_index_o  (cnt_o.count_index),
    .match_count_o  (cnt_o.match_count),
    .last_o         (cnt_o.last)
  );

`ifndef SYNTHESIS
  // a count is only loaded when the output register has room
  a_emit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> status.out_free)
    else $error("count loaded over an untaken item");

  // end of text always stalls requests for the count update
  a_sep_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready && (req_i.req_type == wkc_pkg::REQ_END))
    |=> !req_i.ready)
    else $error("end of text did not stall for the update");

  // the last mark sits on the top table entry
  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_o.valid && cnt_o.last)
    |-> (cnt_o.count_index == 4'(wkc_pkg::TABLE_SIZE - 1)))
    else $error("last mark on wrong entry");

  // while the dump runs no request is taken
  a_dump_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit && !status.dump_last) |=> !req_i.ready)
    else $error("request taken during count dump");
`endif

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the word keyword counter: keyword loads and text
// streams go in, every reported count item is checked against a local model.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // req_type 3 has no meaning in the block and must be dropped
  localparam logic [1:0] REQ_NONE = 2'd3;

  // cycles without any accepted item before the run is declared hung
  localparam int unsigned STALL_LIMIT = 5000;
  // settle time after the last count item, well above the block latency
  localparam int unsigned DRAIN_CYCLES = 40;
  // printed mismatch lines are capped, all of them are counted
  localparam int unsigned PRINT_CAP = 100;

  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  text_byte;
    logic [3:0]  entry_index;
    logic [63:0] entry_chars;
    logic [3:0]  entry_length;
    int          phase;  // idle profile while this item is on the bus
    bit          hold;   // wait for all count items before offering it
  } text_req_t;

  typedef struct packed {
    logic [3:0]  index;
    logic [15:0] count;
    logic        last;
  } count_rpt_t;

  // idle odds in percent per phase: sender / receiver
  int unsigned send_idle_pct [3] = '{24, 86, 0};
  int unsigned recv_idle_pct [3] = '{86, 24, 0};

  logic clk_i;
  logic rst_ni;

  wkc_req_if req_bus ();
  wkc_cnt_if cnt_bus ();

  word_keyword_counter u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .cnt_o  (cnt_bus)
  );

  text_req_t  req_backlog [$];
  count_rpt_t pending_counts [$];
  int unsigned mismatches;
  int          cur_phase;

  // --------------------------------------------------------------------------
  // Local model of the counter
  // --------------------------------------------------------------------------
  bit [63:0]                    kw_chars [wkc_pkg::TABLE_SIZE];
  bit [3:0]                     kw_len   [wkc_pkg::TABLE_SIZE];
  bit [wkc_pkg::COUNT_BITS-1:0] hits     [wkc_pkg::TABLE_SIZE];
  bit [63:0]                    word_buf;
  int unsigned                  word_len;
  bit                           word_long;

  function automatic bit is_alnum(logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  // Word ended: lowest equal entry gets the hit, then the word is dropped.
  task automatic close_word();
    bit [63:0] mask;
    bit        found;
    found = 1'b0;
    if (word_len != 0 && !word_long) begin
      mask = (word_len >= 8) ? '1 : ((64'd1 << (8 * word_len)) - 64'd1);
      for (int i = 0; i < wkc_pkg::TABLE_SIZE; i++) begin
        if (!found && kw_len[i] == word_len && (kw_chars[i] & mask) == word_buf) begin
          if (hits[i] != wkc_pkg::COUNT_MAX) hits[i]++;
          found = 1'b1;
        end
      end
    end
    word_buf  = '0;
    word_len  = 0;
    word_long = 1'b0;
  endtask

  // Apply one accepted request; end of text queues the whole count dump.
  task automatic tally_request(input text_req_t r);
    logic [7:0] c;
    count_rpt_t rpt;
    case (r.kind)
      wkc_pkg::REQ_LOAD: begin
        if (r.entry_index < wkc_pkg::TABLE_SIZE) begin
          kw_chars[r.entry_index] = r.entry_chars;
          kw_len[r.entry_index]   = r.entry_length;
        end
      end
      wkc_pkg::REQ_TEXT: begin
        c = r.text_byte;
        if (!is_alnum(c)) begin
          close_word();
        end else begin
          if (c >= "A" && c <= "Z") c = c + 8'd32;
          if (word_len < wkc_pkg::MAX_WORD_LEN) begin
            word_buf[8 * word_len +: 8] = c;
            word_len++;
          end else begin
            word_long = 1'b1;
          end
        end
      end
      wkc_pkg::REQ_END: begin
        close_word();
        for (int i = 0; i < wkc_pkg::TABLE_SIZE; i++) begin
          rpt.index = 4'(i);
          rpt.count = (32'(hits[i]) > 32'h0000_FFFF) ? 16'hFFFF : 16'(hits[i]);
          rpt.last  = (i == wkc_pkg::TABLE_SIZE - 1);
          pending_counts = {pending_counts, rpt};
          hits[i] = '0;
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_CAP) $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus generation
  // --------------------------------------------------------------------------
  int        gen_phase;
  bit        gen_hold;
  bit [63:0] gen_chars [16];
  int        gen_len   [16];
  bit        gen_plain [16];  // entry holds only lower case letters and digits

  function automatic text_req_t blank_req(logic [1:0] kind);
    text_req_t r;
    r.kind         = kind;
    r.text_byte    = 8'($urandom);
    r.entry_index  = 4'($urandom);
    r.entry_chars  = {$urandom, $urandom};
    r.entry_length = 4'($urandom);
    r.phase        = 0;
    r.hold         = 1'b0;
    return r;
  endfunction

  task automatic push_req(input text_req_t r);
    r.phase  = gen_phase;
    r.hold   = gen_hold;
    gen_hold = 1'b0;
    req_backlog = {req_backlog, r};
  endtask

  task automatic push_load(input logic [3:0] idx, input logic [63:0] chars,
                           input logic [3:0] len, input bit plain);
    text_req_t r;
    r = blank_req(wkc_pkg::REQ_LOAD);
    r.entry_index  = idx;
    r.entry_chars  = chars;
    r.entry_length = len;
    push_req(r);
    gen_chars[idx] = chars;
    gen_len[idx]   = len;
    gen_plain[idx] = plain;
  endtask

  task automatic push_char(input logic [7:0] c);
    text_req_t r;
    r = blank_req(wkc_pkg::REQ_TEXT);
    r.text_byte = c;
    push_req(r);
  endtask

  task automatic push_end();
    push_req(blank_req(wkc_pkg::REQ_END));
  endtask

  function automatic logic [7:0] pick_alnum();
    int unsigned v;
    v = $urandom_range(35);
    return (v < 10) ? 8'("0" + v) : 8'("a" + v - 10);
  endfunction

  function automatic logic [7:0] pick_sep();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (is_alnum(c));
    return c;
  endfunction

  // random case on letters, the block must fold them back
  task automatic push_mixed(input logic [7:0] c);
    if (c >= "a" && c <= "z" && $urandom_range(1)) c = c - 8'd32;
    push_char(c);
  endtask

  // Mostly well-formed words, many of them loaded keywords, some noise.
  task automatic gen_random(input int unsigned n);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned len;
    int          cands [$];
    logic [63:0] chars;
    logic [3:0]  idx;
    stop_at = req_backlog.size() + n;
    while (req_backlog.size() < stop_at) begin
      pick = $urandom_range(99);
      cands.delete();
      for (int i = 0; i < 16; i++)
        if (gen_plain[i] && gen_len[i] >= 1 && gen_len[i] <= wkc_pkg::MAX_WORD_LEN)
          cands = {cands, i};
      if (pick < 10) begin
        idx = 4'($urandom);
        if ($urandom_range(99) < 75) begin
          len   = ($urandom_range(99) < 85) ? $urandom_range(1, 8) : $urandom_range(0, 15);
          chars = {$urandom, $urandom};
          for (int k = 0; k < 8 && k < len; k++) chars[8 * k +: 8] = pick_alnum();
          push_load(idx, chars, 4'(len), len <= wkc_pkg::MAX_WORD_LEN);
        end else begin
          push_load(idx, {$urandom, $urandom}, 4'($urandom), 1'b0);
        end
      end else if (pick < 88) begin
        if (pick < 70 && cands.size() != 0) begin
          idx = 4'(cands[$urandom_range(cands.size() - 1)]);
          for (int k = 0; k < gen_len[idx]; k++) push_mixed(gen_chars[idx][8 * k +: 8]);
          // a keyword with a tail is a different word
          if ($urandom_range(99) < 10) push_mixed(pick_alnum());
        end else begin
          len = ($urandom_range(99) < 25) ? $urandom_range(9, 12) : $urandom_range(1, 8);
          for (int k = 0; k < len; k++) push_mixed(pick_alnum());
        end
        // pending word flushed straight by end of text now and then
        if ($urandom_range(99) < 8) push_end();
        else push_char(pick_sep());
      end else if (pick < 92) begin
        push_req(blank_req(REQ_NONE));
      end else if (pick < 96) begin
        push_char(pick_sep());
      end else begin
        push_end();
      end
    end
    push_end();
  endtask

  task automatic build_stimulus();
    // phase 0: directed corner cases, then random items
    gen_phase = 0;
    push_end();                                            // empty text
    push_load(4'd0,  {48'hA5A5_5A5A_FFFF, 16'h6261}, 4'd2, 1'b1);  // "ab", junk above
    push_load(4'd15, 64'h6867_6665_6463_6261, 4'd8, 1'b1); // longest keyword
    push_load(4'd1,  64'h0000_0000_0000_6261, 4'd2, 1'b1); // same as entry 0
    push_load(4'd2,  {$urandom, $urandom}, 4'd15, 1'b0);   // too long to match
    push_load(4'd3,  64'h0000_0000_0000_4241, 4'd2, 1'b0); // upper case keyword
    push_load(4'd4,  64'h0000_0000_0000_6261, 4'd0, 1'b0); // unused entry
    push_load(4'd5,  {48'hFFFF_FFFF_FFFF, 16'h397A}, 4'd2, 1'b1);  // "z9"
    push_char("A"); push_char("b"); push_char(8'h00);
    push_char("Z"); push_char("9"); push_char(8'hFF);
    for (int k = 0; k < 8; k++) push_char(8'("a" + k));
    push_end();                                            // flushes "abcdefgh"
    push_req(blank_req(REQ_NONE));
    gen_random(90);

    gen_phase = 1;
    gen_hold  = 1'b1;
    gen_random(110);

    gen_phase = 2;
    gen_hold  = 1'b1;
    gen_random(100);
  endtask

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Request driver: offers backlog items, models the gaps of the sender
  // --------------------------------------------------------------------------
  text_req_t on_bus;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_bus.valid        <= 1'b0;
      req_bus.req_type     <= '0;
      req_bus.text_byte    <= '0;
      req_bus.entry_index  <= '0;
      req_bus.entry_chars  <= '0;
      req_bus.entry_length <= '0;
    end else begin
      if (req_bus.valid && req_bus.ready) tally_request(on_bus);
      if (!req_bus.valid || req_bus.ready) begin
        // free slot: offer the next item unless idling or held for the drain
        if (req_backlog.size() != 0 &&
            !(req_backlog[0].hold && pending_counts.size() != 0) &&
            $urandom_range(99) >= send_idle_pct[req_backlog[0].phase]) begin
          on_bus = req_backlog.pop_front();
          req_bus.valid        <= 1'b1;
          req_bus.req_type     <= on_bus.kind;
          req_bus.text_byte    <= on_bus.text_byte;
          req_bus.entry_index  <= on_bus.entry_index;
          req_bus.entry_chars  <= on_bus.entry_chars;
          req_bus.entry_length <= on_bus.entry_length;
          cur_phase            <= on_bus.phase;
        end else begin
          req_bus.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Count monitor: random back-pressure, each item checked against the oldest
  // expected count
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    count_rpt_t want;
    if (!rst_ni) begin
      cnt_bus.ready <= 1'b0;
    end else begin
      if (cnt_bus.valid && cnt_bus.ready) begin
        if (pending_counts.size() == 0) begin
          report_mismatch($sformatf("count item with none expected, index %0d count %0d",
                                    cnt_bus.count_index, cnt_bus.match_count));
        end else begin
          want = pending_counts.pop_front();
          if (cnt_bus.count_index !== want.index)
            report_mismatch($sformatf("count_index got %0d want %0d",
                                      cnt_bus.count_index, want.index));
          if (cnt_bus.match_count !== want.count)
            report_mismatch($sformatf("match_count of entry %0d got %0d want %0d",
                                      want.index, cnt_bus.match_count, want.count));
          if (cnt_bus.last !== want.last)
            report_mismatch($sformatf("last of entry %0d got %0b want %0b",
                                      want.index, cnt_bus.last, want.last));
        end
      end
      cnt_bus.ready <= ($urandom_range(99) >= recv_idle_pct[cur_phase]);
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: no item accepted on either side for too long means a hang
  // --------------------------------------------------------------------------
  int unsigned stall_cycles;

  always @(posedge clk_i) begin
    if (!rst_ni || (req_bus.valid && req_bus.ready) || (cnt_bus.valid && cnt_bus.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", stall_cycles);
      $display("TEST FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni               = 1'b0;
    req_bus.valid        = 1'b0;
    req_bus.req_type     = '0;
    req_bus.text_byte    = '0;
    req_bus.entry_index  = '0;
    req_bus.entry_chars  = '0;
    req_bus.entry_length = '0;
    cnt_bus.ready        = 1'b0;
    cur_phase            = 0;
    mismatches           = 0;
    stall_cycles         = 0;
    gen_hold             = 1'b0;
    build_stimulus();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // everything sent and every count item back, then let the block settle
    do @(posedge clk_i);
    while (req_backlog.size() != 0 || req_bus.valid || pending_counts.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/wkc_pkg.sv
hw/rtl/wkc_req_if.sv
hw/rtl/wkc_cnt_if.sv
hw/rtl/wkc_ctrl.sv
hw/rtl/wkc_dp.sv
hw/rtl/word_keyword_counter.sv
test/tb_top.sv
